/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define AST_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define AST_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wnrs_pkg.sv */
// Shared constants, codes and control/status types of the route selector.
// No dependencies.
package wnrs_pkg;

  localparam int unsigned NODES  = 16;
  localparam int unsigned WINDOW = 100;
  localparam int unsigned NIW    = $clog2(NODES);
  localparam int unsigned FW     = $clog2(WINDOW + 1);
  localparam int unsigned HW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned AW     = $clog2(NODES * WINDOW);
  localparam int unsigned SUMW   = 16 + FW;
  localparam int unsigned DVW    = 29;
  localparam int unsigned DSW    = 33;
  localparam int unsigned SCW    = 21;

  localparam logic [15:0] LAT_DEFAULT = 16'd1600;
  localparam logic [15:0] W_DEFAULT   = 16'd4096;
  localparam logic [15:0] W_MIN       = 16'd410;
  localparam logic [15:0] W_MAX       = 16'd40960;
  localparam logic [15:0] EPS_Q20     = 16'd1049;
  localparam logic [15:0] CONF_FB     = 16'd16384;
  localparam logic [15:0] CONF_MAX    = 16'd32768;

  localparam logic [2:0] STR_LAT    = 3'd0;
  localparam logic [2:0] STR_LOAD   = 3'd1;
  localparam logic [2:0] STR_TPUT   = 3'd2;
  localparam logic [2:0] STR_COST   = 3'd3;
  localparam logic [2:0] STR_HYBRID = 3'd4;

  localparam logic [2:0] REG_STRATEGY = 3'd0;
  localparam logic [2:0] REG_COUNT    = 3'd1;
  localparam logic [2:0] REG_LOCAL    = 3'd2;
  localparam logic [2:0] REG_LRATE    = 3'd3;
  localparam logic [2:0] REG_ENABLE   = 3'd4;

  typedef enum logic [2:0] {
    DIV_AVG,
    DIV_LOAD,
    DIV_A,
    DIV_B,
    DIV_SC
  } div_op_e;

  typedef struct packed {
    logic    latch_in;
    logic    upd_rd;
    logic    upd_wr;
    logic    upd_avg;
    logic    upd_mul;
    logic    upd_wgt;
    logic    p_init;
    logic    p_node;
    logic    p_load;
    logic    p_a;
    logic    p_b;
    logic    p_mul;
    logic    p_sc;
    logic    p_cmp;
    logic    div_start;
    div_op_e div_op;
    logic    out_load;
  } wnrs_cmd_t;

  typedef struct packed {
    logic enable;
    logic count_zero;
    logic last_node;
    logic sc_div;
    logic div_done;
  } wnrs_sts_t;

endpackage

/* rtl/wnrs_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on wnrs_pkg.
module wnrs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wnrs_pkg::DVW-1:0]   dividend_i,
  input  logic [wnrs_pkg::DSW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [wnrs_pkg::DVW-1:0]   quotient_o
);
  import wnrs_pkg::*;

  localparam int unsigned CNTW = $clog2(DVW + 1);

  logic [DSW-1:0]  rem_q, dsr_q;
  logic [DVW-1:0]  dvd_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DSW:0]    trial;
  logic            ge;

  assign trial = {rem_q, dvd_q[DVW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DSW'(trial - {1'b0, dsr_q}) : trial[DSW-1:0];
      dvd_q <= {dvd_q[DVW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

/* rtl/wnrs_dpath.sv */
// Datapath: config registers, per-node tables, sample window memory,
// multipliers, the shared divider and the result register. Depends on wnrs_pkg.
module wnrs_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wnrs_pkg::wnrs_cmd_t cmd_i,
  output wnrs_pkg::wnrs_sts_t sts_o,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [3:0]          node_i,
  input  logic [15:0]         sample_latency_i,
  input  logic                success_i,
  output logic [3:0]          target_node_o,
  output logic [15:0]         predicted_latency_o,
  output logic [15:0]         load_score_o,
  output logic [15:0]         confidence_o,
  output logic                fallback_o
);
  import wnrs_pkg::*;

  // ceil(2^27 / 10): exact floor(x / 10) for x below 2^26
  localparam logic [23:0] RECIP10 = 24'd13421773;

  // configuration
  logic [2:0]  strategy_q;
  logic [4:0]  node_count_q;
  logic [3:0]  local_node_q;
  logic [15:0] lrate_q;
  logic        enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q   <= STR_HYBRID;
      node_count_q <= '0;
      local_node_q <= '0;
      lrate_q      <= 16'd655;
      enable_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STRATEGY: strategy_q   <= cfg_data_i[2:0];
        REG_COUNT:    node_count_q <= cfg_data_i[4:0];
        REG_LOCAL:    local_node_q <= cfg_data_i[3:0];
        REG_LRATE:    lrate_q      <= cfg_data_i;
        REG_ENABLE:   enable_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // request latch
  logic [NIW-1:0] un_q;
  logic [15:0]    smp_q;
  logic           succ_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      un_q   <= node_i[NIW-1:0];
      smp_q  <= sample_latency_i;
      succ_q <= success_i;
    end
  end

  // per-node tables
  logic [FW-1:0]   fill_q [NODES];
  logic [HW-1:0]   head_q [NODES];
  logic [SUMW-1:0] sum_q  [NODES];
  logic [15:0]     avg_q  [NODES];
  logic [15:0]     wgt_q  [NODES];
  logic            known_q[NODES];

  // sample window memory, no reset
  logic [15:0]   win_mem [NODES*WINDOW];
  logic [15:0]   old_q;
  logic [AW-1:0] addr;

  assign addr = AW'(un_q * WINDOW) + AW'(head_q[un_q]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_rd) begin
      old_q <= win_mem[addr];
    end
    if (cmd_i.upd_wr) begin
      win_mem[addr] <= smp_q;
    end
  end

  // window bookkeeping
  logic            full;
  logic [FW-1:0]   fill_nx;
  logic [SUMW-1:0] sum_nx;
  logic [HW-1:0]   head_nx;

  assign full    = fill_q[un_q] == FW'(WINDOW);
  assign fill_nx = full ? fill_q[un_q] : fill_q[un_q] + FW'(1);
  assign sum_nx  = full ? sum_q[un_q] - SUMW'(old_q) + SUMW'(smp_q)
                        : sum_q[un_q] + SUMW'(smp_q);
  assign head_nx = (head_q[un_q] == HW'(WINDOW - 1)) ? '0 : head_q[un_q] + HW'(1);

  // weight adaptation
  logic signed [16:0] diff;
  logic signed [33:0] uprod_q;
  logic signed [34:0] p35, pneg, step;
  logic [15:0]        wbase;
  logic signed [35:0] wsum;
  logic [15:0]        wnew;

  assign diff  = $signed({1'b0, smp_q}) - $signed({1'b0, avg_q[un_q]});
  assign p35   = $signed({uprod_q[33], uprod_q});
  assign pneg  = -p35;
  assign step  = succ_q ? (p35 >>> 8) : (pneg >>> 9);
  assign wbase = known_q[un_q] ? wgt_q[un_q] : 16'd0;
  assign wsum  = $signed({20'd0, wbase}) + $signed({step[34], step});

  always_comb begin
    if (wsum < $signed({20'd0, W_MIN})) begin
      wnew = W_MIN;
    end else if (wsum > $signed({20'd0, W_MAX})) begin
      wnew = W_MAX;
    end else begin
      wnew = wsum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_mul) begin
      uprod_q <= $signed({1'b0, lrate_q}) * diff;
    end
  end

  // divider
  logic [DVW-1:0] dvd, quo;
  logic [DSW-1:0] dsr;
  logic           div_done;

  // predict registers
  logic [NIW-1:0] i_q, bnode_q;
  logic [15:0]    lat_q, w_q, load_q, blat_q, bload_q;
  logic [16:0]    a_q;
  logic [19:0]    b_q;
  logic [32:0]    pprod_q;
  logic [SCW-1:0] sc_q, best_q, sc_d;
  logic           fb_q;
  logic [4:0]     count_eff;
  logic [SCW-1:0] half_best;
  logic [22:0]    hsum;
  logic [46:0]    hprod;

  assign count_eff = (node_count_q > 5'(NODES)) ? 5'(NODES) : node_count_q;

  // hybrid score: divide by ten through a reciprocal multiply
  assign hsum  = 23'({w_q, 6'd0}) + 23'(a_q) * 23'(3) + 23'(b_q) * 23'(3);
  assign hprod = 47'(hsum) * 47'(RECIP10);

  always_comb begin
    case (cmd_i.div_op)
      DIV_AVG: begin
        dvd = DVW'(sum_q[un_q]);
        dsr = DSW'(fill_q[un_q]);
      end
      DIV_LOAD: begin
        dvd = DVW'(2**28);
        dsr = DSW'({w_q, 8'd0}) + DSW'(EPS_Q20);
      end
      DIV_A: begin
        dvd = DVW'(2**20);
        dsr = DSW'(lat_q) + DSW'(16);
      end
      DIV_B: begin
        dvd = DVW'(2560 * 2**16);
        dsr = DSW'(load_q) * DSW'(10) + DSW'(256);
      end
      DIV_SC: begin
        // cost min score
        dvd = DVW'(2**28);
        dsr = pprod_q + DSW'(4096);
      end
      default: begin
        dvd = '0;
        dsr = DSW'(1);
      end
    endcase
  end

  wnrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dsr),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) begin
        fill_q[n]  <= '0;
        head_q[n]  <= '0;
        sum_q[n]   <= '0;
        avg_q[n]   <= '0;
        wgt_q[n]   <= '0;
        known_q[n] <= 1'b0;
      end
    end else begin
      if (cmd_i.upd_wr) begin
        fill_q[un_q] <= fill_nx;
        sum_q[un_q]  <= sum_nx;
        head_q[un_q] <= head_nx;
      end
      if (cmd_i.upd_avg) begin
        avg_q[un_q] <= quo[15:0];
      end
      if (cmd_i.upd_wgt) begin
        wgt_q[un_q]   <= wnew;
        known_q[un_q] <= 1'b1;
      end
    end
  end

  // score selection
  always_comb begin
    case (strategy_q)
      STR_LAT:    sc_d = SCW'(a_q);
      STR_LOAD:   sc_d = SCW'(b_q);
      STR_TPUT:   sc_d = SCW'(pprod_q >> 12);
      STR_COST:   sc_d = SCW'(quo);
      STR_HYBRID: sc_d = SCW'(hprod >> 27);
      default:    sc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.p_init) begin
      i_q  <= '0;
      fb_q <= count_eff == 5'd0;
    end
    if (cmd_i.p_node) begin
      lat_q <= (fill_q[i_q] != '0) ? avg_q[i_q] : LAT_DEFAULT;
      w_q   <= known_q[i_q] ? wgt_q[i_q] : W_DEFAULT;
    end
    if (cmd_i.p_load) begin
      load_q <= (quo > DVW'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
    end
    if (cmd_i.p_a) begin
      a_q <= quo[16:0];
    end
    if (cmd_i.p_b) begin
      b_q <= quo[19:0];
    end
    if (cmd_i.p_mul) begin
      pprod_q <= (strategy_q == STR_TPUT) ? 33'(w_q) * 33'(a_q)
                                          : 33'(lat_q) * 33'(load_q);
    end
    if (cmd_i.p_sc) begin
      sc_q <= sc_d;
    end
    if (cmd_i.p_cmp) begin
      if (i_q == '0 || sc_q > best_q) begin
        best_q  <= sc_q;
        bnode_q <= i_q;
        blat_q  <= lat_q;
        bload_q <= load_q;
      end
      i_q <= i_q + NIW'(1);
    end
  end

  // result register
  assign half_best = best_q >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (fb_q) begin
        target_node_o       <= local_node_q;
        predicted_latency_o <= '0;
        load_score_o        <= '0;
        confidence_o        <= CONF_FB;
        fallback_o          <= 1'b1;
      end else begin
        target_node_o       <= 4'(bnode_q);
        predicted_latency_o <= blat_q;
        load_score_o        <= bload_q;
        confidence_o        <= (half_best > SCW'(CONF_MAX)) ? CONF_MAX : half_best[15:0];
        fallback_o          <= 1'b0;
      end
    end
  end

  assign sts_o.enable     = enable_q;
  assign sts_o.count_zero = count_eff == 5'd0;
  assign sts_o.last_node  = (5'(i_q) + 5'd1) == count_eff;
  assign sts_o.sc_div     = strategy_q == STR_COST;
  assign sts_o.div_done   = div_done;
endmodule

/* rtl/wnrs_ctrl.sv */
// Sequencer: steps update and predict requests through the datapath and
// owns the channel handshakes. Depends on wnrs_pkg.
module wnrs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                cmd_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wnrs_pkg::wnrs_cmd_t cmd_o,
  input  wnrs_pkg::wnrs_sts_t sts_i
);
  import wnrs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_U_RD, S_U_WR, S_U_DAVG, S_U_WAVG, S_U_MUL, S_U_WGT,
    S_P_START, S_P_NODE, S_P_DLOAD, S_P_WLOAD, S_P_DA, S_P_WA,
    S_P_DB, S_P_WB, S_P_MUL, S_P_SC, S_P_WSC, S_P_CMP, S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, emit_ok;

  assign accept  = (state_q == S_IDLE) && in_valid_i;
  assign emit_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    cmd_o.div_op = DIV_AVG;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch_in = 1'b1;
          if (cmd_i) begin
            state_d = sts_i.enable ? S_U_RD : S_IDLE;
          end else begin
            state_d = S_P_START;
          end
        end
      end
      S_U_RD: begin
        cmd_o.upd_rd = 1'b1;
        state_d = S_U_WR;
      end
      S_U_WR: begin
        cmd_o.upd_wr = 1'b1;
        state_d = S_U_DAVG;
      end
      S_U_DAVG: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_AVG;
        state_d = S_U_WAVG;
      end
      S_U_WAVG: begin
        if (sts_i.div_done) begin
          cmd_o.upd_avg = 1'b1;
          state_d = S_U_MUL;
        end
      end
      S_U_MUL: begin
        cmd_o.upd_mul = 1'b1;
        state_d = S_U_WGT;
      end
      S_U_WGT: begin
        cmd_o.upd_wgt = 1'b1;
        state_d = S_IDLE;
      end
      S_P_START: begin
        cmd_o.p_init = 1'b1;
        state_d = sts_i.count_zero ? S_EMIT : S_P_NODE;
      end
      S_P_NODE: begin
        cmd_o.p_node = 1'b1;
        state_d = S_P_DLOAD;
      end
      S_P_DLOAD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_LOAD;
        state_d = S_P_WLOAD;
      end
      S_P_WLOAD: begin
        if (sts_i.div_done) begin
          cmd_o.p_load = 1'b1;
          state_d = S_P_DA;
        end
      end
      S_P_DA: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_A;
        state_d = S_P_WA;
      end
      S_P_WA: begin
        if (sts_i.div_done) begin
          cmd_o.p_a = 1'b1;
          state_d = S_P_DB;
        end
      end
      S_P_DB: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_B;
        state_d = S_P_WB;
      end
      S_P_WB: begin
        if (sts_i.div_done) begin
          cmd_o.p_b = 1'b1;
          state_d = S_P_MUL;
        end
      end
      S_P_MUL: begin
        cmd_o.p_mul = 1'b1;
        state_d = S_P_SC;
      end
      S_P_SC: begin
        if (sts_i.sc_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_SC;
          state_d = S_P_WSC;
        end else begin
          cmd_o.p_sc = 1'b1;
          state_d = S_P_CMP;
        end
      end
      S_P_WSC: begin
        if (sts_i.div_done) begin
          cmd_o.p_sc = 1'b1;
          state_d = S_P_CMP;
        end
      end
      S_P_CMP: begin
        cmd_o.p_cmp = 1'b1;
        state_d = sts_i.last_node ? S_EMIT : S_P_NODE;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
endmodule

/* rtl/weighted_node_route_selector.sv */
// Top level of the weighted node route selector: sequencer plus datapath.
// Depends on wnrs_pkg, wnrs_ctrl, wnrs_dpath (and wnrs_div below it).
//
// Input (in_valid_i / in_stall_o): a request is cmd_i, node_i,
//  sample_latency_i, success_i. cmd 1 pushes a latency sample for node_i and
//  adapts its weight, no result; cmd 0 asks for a route, one result on
//  out_valid_o / out_stall_i, held in an output register.
// Config (cfg_valid_i / cfg_ready_o, always ready): index 0 strategy, 1 node
//  count, 2 local node, 3 learning rate, 4 enable. Write only when idle.
// Sequencing: one request at a time; divisions share one restoring divider.
//  - update: one division for the window average; dropped if enable is 0.
//  - route: three divisions per node in use, plus a fourth for cost min;
//    with no node in use the fallback result goes straight out.
// Reset: asynchronous, active low; clears the config registers, tables and
//  sequencer to their defaults. The sample window memory is not cleared: an
//  entry's old value is used only once the window has wrapped over it.
// Receiver stall: the result stays in the output register; a finished route
//  waits in the sequencer, input stalled, until that register frees up.
module weighted_node_route_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  node_i,
  input  logic [15:0] sample_latency_i,
  input  logic        success_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  target_node_o,
  output logic [15:0] predicted_latency_o,
  output logic [15:0] load_score_o,
  output logic [15:0] confidence_o,
  output logic        fallback_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import wnrs_pkg::*;

  wnrs_cmd_t cmd;
  wnrs_sts_t sts;

  // config writes are taken on any cycle
  assign cfg_ready_o = 1'b1;

  wnrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wnrs_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_valid_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .node_i              (node_i),
    .sample_latency_i    (sample_latency_i),
    .success_i           (success_i),
    .target_node_o       (target_node_o),
    .predicted_latency_o (predicted_latency_o),
    .load_score_o        (load_score_o),
    .confidence_o        (confidence_o),
    .fallback_o          (fallback_o)
  );
endmodule

/* rtl/wnrs_chk.sv */
// Port-level checker for the route selector, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module wnrs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  target_node_o,
  input logic [15:0] predicted_latency_o,
  input logic [15:0] load_score_o,
  input logic [15:0] confidence_o,
  input logic        fallback_o
);
  `AST_NEXT(a_hold_valid, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `AST_NEXT(a_hold_data, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(target_node_o) && $stable(confidence_o), "stalled result changed")
  `AST_IMPL(a_fallback, clk_i, rst_ni, out_valid_o && fallback_o, predicted_latency_o == 16'd0 && load_score_o == 16'd0 && confidence_o == 16'd16384, "bad fallback result")
  `AST_IMPL(a_conf_cap, clk_i, rst_ni, out_valid_o, confidence_o <= 16'd32768, "confidence above one")
endmodule

bind weighted_node_route_selector wnrs_chk u_wnrs_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .target_node_o       (target_node_o),
  .predicted_latency_o (predicted_latency_o),
  .load_score_o        (load_score_o),
  .confidence_o        (confidence_o),
  .fallback_o          (fallback_o)
);

/* tb/sv/tb_weighted_node_route_selector.sv */
// Self-checking testbench for weighted_node_route_selector: random and directed requests,
// an in-bench route predictor and a scoreboard. Depends on wnrs_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_weighted_node_route_selector;
  import wnrs_pkg::*;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;
  localparam logic [2:0] STR_UNUSED = 3'd7;  // beyond the defined strategies
  localparam logic [2:0] REG_NONE   = 3'd7;  // index with no register behind it
  localparam int IDLE_PCT    = 19;
  localparam int HOLD_CYCLES = 3000;
  localparam int STALL_LIMIT = 40000;  // above the longest route plus the receiver hold-off
  localparam int SETTLE      = 120;    // covers a trailing update, with margin

  typedef struct {
    logic        cmd;
    logic [3:0]  node;
    logic [15:0] lat;
    logic        ok;
  } request_t;

  typedef struct {
    logic [3:0]  node;
    logic [15:0] lat;
    logic [15:0] load;
    logic [15:0] conf;
    logic        fb;
  } route_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = CMD_PREDICT;
  logic [3:0]  node_i = '0;
  logic [15:0] sample_latency_i = '0;
  logic        success_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  target_node_o;
  logic [15:0] predicted_latency_o;
  logic [15:0] load_score_o;
  logic [15:0] confidence_o;
  logic        fallback_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  weighted_node_route_selector DUT (.*);

  always #1 clk_i = ~clk_i;

  // ---- predictor state: configuration and per-node tables ----
  logic [2:0]  strategy_q;
  logic [4:0]  count_q;
  logic [3:0]  local_q;
  logic [15:0] lrate_q;
  logic        enable_q;
  logic [15:0] win_mem [NODES*WINDOW];
  int          fill_q [NODES];
  int          head_q [NODES];
  longint      sum_q [NODES];
  logic [15:0] avg_q [NODES];
  logic [15:0] wgt_q [NODES];
  bit          known_q [NODES];

  request_t pending_reqs[$];
  route_t   routes_due[$];
  int  pushed_cnt = 0;
  int  accepted_cnt = 0;
  int  mismatches = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  bit  in_taken = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  function automatic void reset_tables();
    strategy_q = STR_HYBRID; count_q = '0; local_q = '0; lrate_q = 16'd655; enable_q = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      fill_q[i] = 0; head_q[i] = 0; sum_q[i] = 0;
      avg_q[i] = '0; wgt_q[i] = '0; known_q[i] = 1'b0;
    end
  endfunction

  function automatic void write_setting(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_STRATEGY: strategy_q = val[2:0];
      REG_COUNT:    count_q    = val[4:0];
      REG_LOCAL:    local_q    = val[3:0];
      REG_LRATE:    lrate_q    = val;
      REG_ENABLE:   enable_q   = val[0];
      default: ;
    endcase
  endfunction

  // Push one latency sample and adapt the node weight.
  function automatic void learn_sample(request_t r);
    int     n;
    int     slot;
    longint avg, p, step, w;
    n = r.node;
    if (!enable_q) return;
    if (head_q[n] >= WINDOW) head_q[n] = 0;
    slot = n * WINDOW + head_q[n];
    if (fill_q[n] < WINDOW) fill_q[n]++;
    else sum_q[n] -= win_mem[slot];
    win_mem[slot] = r.lat;
    sum_q[n] += r.lat;
    head_q[n]++;
    if (head_q[n] >= WINDOW) head_q[n] = 0;
    avg = sum_q[n] / fill_q[n];
    avg_q[n] = avg[15:0];
    p = longint'(lrate_q) * (longint'(r.lat) - avg);
    step = r.ok ? (p >>> 8) : ((-p) >>> 9);  // arithmetic shift = floor
    w = (known_q[n] ? longint'(wgt_q[n]) : 0) + step;
    // signed compare, a negative sum clamps to the floor
    if (w < longint'(W_MIN)) w = longint'(W_MIN);
    if (w > longint'(W_MAX)) w = longint'(W_MAX);
    wgt_q[n] = w[15:0];
    known_q[n] = 1'b1;
  endfunction

  // Score every node in use; first highest score wins.
  function automatic route_t pick_route();
    route_t res;
    int cnt;
    longint unsigned lat, w, load, a, b, sc, best;
    cnt = (count_q > NODES) ? NODES : count_q;
    if (cnt == 0) begin
      res = '{node: local_q, lat: '0, load: '0, conf: CONF_FB, fb: 1'b1};
      return res;
    end
    best = 0;
    res.fb = 1'b0;
    for (int i = 0; i < cnt; i++) begin
      lat  = fill_q[i] ? avg_q[i] : LAT_DEFAULT;
      w    = known_q[i] ? wgt_q[i] : W_DEFAULT;
      load = (64'd1 << 28) / (w * 256 + EPS_Q20);
      if (load > 64'hFFFF) load = 64'hFFFF;
      a = (64'd1 << 20) / (lat + 16);
      b = (64'd2560 << 16) / (10 * load + 256);
      case (strategy_q)
        STR_LAT:    sc = a;
        STR_LOAD:   sc = b;
        STR_TPUT:   sc = (w * a) >> 12;
        STR_COST:   sc = (64'd1 << 28) / (lat * load + 4096);
        STR_HYBRID: sc = (64 * w + 3 * a + 3 * b) / 10;
        default:    sc = 0;
      endcase
      if (i == 0 || sc > best) begin
        best = sc;
        res.node = i[3:0];
        res.lat = lat[15:0];
        res.load = load[15:0];
      end
    end
    best = best >> 1;
    res.conf = (best > CONF_MAX) ? CONF_MAX : best[15:0];
    return res;
  endfunction

  // ---- sender: fed from pending_reqs, changes at falling edge ----
  always @(posedge clk_i) in_taken <= in_valid_i && !in_stall_o;

  always @(negedge clk_i) begin
    request_t r;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        r = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= r.cmd;
        node_i <= r.node;
        sample_latency_i <= r.lat;
        success_i <= r.ok;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---- receiver: random stall, plus one long hold-off on request ----
  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---- monitor: input acceptance drives the predictor, results checked ----
  always @(posedge clk_i) begin
    request_t r;
    route_t   exp_r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      r = '{cmd: cmd_i, node: node_i, lat: sample_latency_i, ok: success_i};
      accepted_cnt++;
      if (r.cmd == CMD_UPDATE) learn_sample(r);
      else routes_due = {routes_due, pick_route()};
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (routes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: node %0d", target_node_o);
      end else begin
        exp_r = routes_due.pop_front();
        if (target_node_o !== exp_r.node || predicted_latency_o !== exp_r.lat ||
            load_score_o !== exp_r.load || confidence_o !== exp_r.conf ||
            fallback_o !== exp_r.fb) begin
          mismatches++;
          if (mismatches <= 10)
            $display("route mismatch: exp node %0d lat %0d load %0d conf %0d fb %0b,",
                     exp_r.node, exp_r.lat, exp_r.load, exp_r.conf, exp_r.fb,
                     " got %0d %0d %0d %0d %0b",
                     target_node_o, predicted_latency_o, load_score_o, confidence_o,
                     fallback_o);
        end
      end
    end
  end

  // ---- watchdog: cycles without any handshake ----
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    write_setting(idx, val);
  endtask

  task automatic cfg_close();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send(logic cmd, logic [3:0] node, logic [15:0] lat, logic ok);
    request_t r;
    r = '{cmd: cmd, node: node, lat: lat, ok: ok};
    pending_reqs = {pending_reqs, r};
    pushed_cnt++;
  endtask

  // Wait until every request is taken and every route has come, then let
  // a trailing update finish.
  task automatic drain();
    do @(posedge clk_i); while (accepted_cnt != pushed_cnt || routes_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_latency();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(4000));
    endcase
  endfunction

  task automatic random_burst(int n, int span);
    logic [3:0] nd;
    for (int i = 0; i < n; i++) begin
      nd = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(span));
      if ($urandom_range(99) < 60)
        send(CMD_UPDATE, nd, rand_latency(), 1'($urandom_range(1)));
      else
        send(CMD_PREDICT, 4'($urandom_range(15)), 16'($urandom_range(65535)),
             1'($urandom_range(1)));
    end
  endtask

  initial begin
    int cnt;
    reset_tables();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset defaults give the fallback route at local node 0.
    send(CMD_PREDICT, 4'd0, 16'd0, 1'b0);
    send(CMD_UPDATE, 4'd0, 16'd500, 1'b1);  // ignored, learning is off
    send(CMD_PREDICT, 4'd0, 16'd0, 1'b0);
    drain();
    cfg_write(REG_ENABLE, 16'd1);
    cfg_write(REG_COUNT, 16'd3);
    cfg_write(REG_LRATE, 16'hFFFF);
    cfg_write(REG_LOCAL, 16'd15);
    cfg_write(REG_STRATEGY, 16'(STR_LAT));
    cfg_close();
    // Field extremes, both outcomes, a node beyond the count.
    send(CMD_UPDATE, 4'd0, 16'h0000, 1'b1);
    send(CMD_UPDATE, 4'd1, 16'hFFFF, 1'b0);
    send(CMD_UPDATE, 4'd2, 16'hFFFF, 1'b1);
    send(CMD_UPDATE, 4'd15, 16'd100, 1'b0);
    send(CMD_UPDATE, 4'd0, 16'd1, 1'b0);
    send(CMD_PREDICT, 4'd0, 16'd0, 1'b0);
    drain();
    // Every strategy, the undefined codes included.
    for (int s = STR_LOAD; s <= STR_UNUSED; s++) begin
      cfg_write(REG_STRATEGY, 16'(s));
      cfg_close();
      send(CMD_PREDICT, 4'd0, 16'd0, 1'b0);
      drain();
    end
    // Count above the table size saturates; write to an index with no register.
    cfg_write(REG_STRATEGY, 16'(STR_HYBRID));
    cfg_write(REG_COUNT, 16'd31);
    cfg_write(REG_NONE, 16'hFFFF);
    cfg_close();
    send(CMD_PREDICT, 4'd0, 16'd0, 1'b0);
    drain();
    // Back to an empty cluster with another local node.
    cfg_write(REG_COUNT, 16'd0);
    cfg_write(REG_LOCAL, 16'd9);
    cfg_close();
    send(CMD_PREDICT, 4'd0, 16'd0, 1'b0);
    send(CMD_UPDATE, 4'd3, 16'd40, 1'b1);
    drain();

    // Back pressure: empty cluster gives fast routes, receiver holds off.
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) send(CMD_PREDICT, 4'($urandom_range(15)), 16'd0, 1'b0);
    drain();
    no_idle = 1'b0;

    // Random phases: settings change between phases, mostly small clusters.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        3:       cnt = 16;
        7:       cnt = 31;
        default: cnt = $urandom_range(5);
      endcase
      cfg_write(REG_COUNT, 16'(cnt));
      cfg_write(REG_STRATEGY,
                16'((ph % 6 == 5) ? $urandom_range(7) : $urandom_range(4)));
      cfg_write(REG_LOCAL, 16'($urandom_range(15)));
      case (ph % 4)
        0:       cfg_write(REG_LRATE, 16'hFFFF);
        1:       cfg_write(REG_LRATE, 16'd0);
        default: cfg_write(REG_LRATE, 16'($urandom_range(65535)));
      endcase
      cfg_write(REG_ENABLE, (ph == 9) ? 16'd0 : 16'd1);
      cfg_close();
      no_idle = (ph == 5);
      random_burst((cnt > 5) ? 30 : 70, (cnt > 15) ? 15 : cnt);
      drain();
    end

    if (mismatches == 0 && routes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
